// File: hw/rtl/clrm_pkg.sv
// ----------------------------------------------------------------------------
// clrm_pkg
// Shared types, substring table and verdict rules of the command line
// rule matcher.
// ----------------------------------------------------------------------------
package clrm_pkg;

	localparam int CHAR_W    = 16;
	localparam int WIN_DEPTH = 22;
	localparam int WIN_LEN   = WIN_DEPTH + 1;
	localparam int PAT_COUNT = 29;
	localparam int PAT_BITS  = 8 * WIN_LEN;

	localparam logic [CHAR_W-1:0] UPPER_FIRST = 16'h0041;
	localparam logic [CHAR_W-1:0] UPPER_LAST  = 16'h005A;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 16'h0020;
	localparam logic [CHAR_W-1:0] NUL_CHAR    = 16'h0000;

	typedef enum logic [2:0] {
		VERDICT_NONE,
		VERDICT_SHADOW_DELETE,
		VERDICT_HIDDEN_SHELL,
		VERDICT_ENCODED,
		VERDICT_POLICY_BYPASS,
		VERDICT_DOWNLOAD,
		VERDICT_LOLBIN
	} verdict_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              last;
	} char_item_t;

	typedef struct packed {
		verdict_t verdict;
	} res_item_t;

	typedef logic [PAT_COUNT-1:0] pat_flags_t;

	// flag positions
	localparam int P_SHADOW_TOOL  = 0;
	localparam int P_DELETE       = 1;
	localparam int P_SHADOW       = 2;
	localparam int P_SHADOWCOPY   = 3;
	localparam int P_BACKUP_TOOL  = 4;
	localparam int P_CATALOG      = 5;
	localparam int P_PS_FULL      = 6;
	localparam int P_PS_CORE      = 7;
	localparam int P_WINSTYLE_LNG = 8;
	localparam int P_WINSTYLE_W   = 9;
	localparam int P_WINSTYLE_WIN = 10;
	localparam int P_ENC_SHORT    = 11;
	localparam int P_ENC_LONG     = 12;
	localparam int P_EXEC_LONG    = 13;
	localparam int P_EXEC_EP      = 14;
	localparam int P_EXEC_TIGHT   = 15;
	localparam int P_DL_STRING    = 16;
	localparam int P_DL_FILE      = 17;
	localparam int P_WEBREQ       = 18;
	localparam int P_WEBCLIENT    = 19;
	localparam int P_BITS         = 20;
	localparam int P_CERT_TOOL    = 21;
	localparam int P_URLCACHE     = 22;
	localparam int P_HTA_HOST     = 23;
	localparam int P_HTTP         = 24;
	localparam int P_JS           = 25;
	localparam int P_VBS          = 26;
	localparam int P_DLL_HOST     = 27;
	localparam int P_JS_URI       = 28;

	// right-justified: byte 0 is the last character, zero bytes are unused
	localparam logic [PAT_BITS-1:0] PAT_TEXT [PAT_COUNT] = '{
		PAT_BITS'({"vss", "admin"}),
		PAT_BITS'("delete"),
		PAT_BITS'("shadow"),
		PAT_BITS'("shadowcopy"),
		PAT_BITS'({"wb", "admin"}),
		PAT_BITS'("catalog"),
		PAT_BITS'({"power", "shell"}),
		PAT_BITS'("pwsh"),
		PAT_BITS'("-windowstyle hidden"),
		PAT_BITS'("-w hidden"),
		PAT_BITS'("-win hidden"),
		PAT_BITS'("-enc "),
		PAT_BITS'("-encodedcommand "),
		PAT_BITS'("-executionpolicy bypass"),
		PAT_BITS'("-ep bypass"),
		PAT_BITS'("-epbypass"),
		PAT_BITS'("downloadstring"),
		PAT_BITS'("downloadfile"),
		PAT_BITS'("invoke-webrequest"),
		PAT_BITS'("net.webclient"),
		PAT_BITS'("start-bitstransfer"),
		PAT_BITS'({"cert", "util"}),
		PAT_BITS'("-urlcache"),
		PAT_BITS'({"msh", "ta"}),
		PAT_BITS'("http"),
		PAT_BITS'("javascript"),
		PAT_BITS'("vbscript"),
		PAT_BITS'({"run", "dll32"}),
		PAT_BITS'("javascript:")
	};

	function automatic verdict_t decide(input pat_flags_t f);
		logic ps;
		verdict_t v;
		ps = f[P_PS_FULL] | f[P_PS_CORE];
		priority if ((f[P_SHADOW_TOOL] && f[P_DELETE] && f[P_SHADOW]) ||
				(f[P_SHADOWCOPY] && f[P_DELETE]) ||
				(f[P_BACKUP_TOOL] && f[P_DELETE] && f[P_CATALOG])) begin
			v = VERDICT_SHADOW_DELETE;
		end else if (ps && (f[P_WINSTYLE_LNG] || f[P_WINSTYLE_W] || f[P_WINSTYLE_WIN])) begin
			v = VERDICT_HIDDEN_SHELL;
		end else if (ps && (f[P_ENC_SHORT] || f[P_ENC_LONG])) begin
			v = VERDICT_ENCODED;
		end else if (ps && (f[P_EXEC_LONG] || f[P_EXEC_EP] || f[P_EXEC_TIGHT])) begin
			v = VERDICT_POLICY_BYPASS;
		end else if (f[P_DL_STRING] || f[P_DL_FILE] || f[P_WEBREQ] || f[P_WEBCLIENT] ||
				f[P_BITS]) begin
			v = VERDICT_DOWNLOAD;
		end else if ((f[P_CERT_TOOL] && f[P_URLCACHE]) ||
				(f[P_HTA_HOST] && (f[P_HTTP] || f[P_JS] || f[P_VBS])) ||
				(f[P_DLL_HOST] && f[P_JS_URI])) begin
			v = VERDICT_LOLBIN;
		end else begin
			v = VERDICT_NONE;
		end
		return v;
	endfunction

endpackage

// File: hw/rtl/clrm_ifs.sv
// ----------------------------------------------------------------------------
// clrm_ifs
// Valid/ready stream interfaces for characters and verdicts.
// ----------------------------------------------------------------------------
interface clrm_char_if;
	import clrm_pkg::*;
	logic       valid;
	logic       ready;
	char_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface clrm_res_if;
	import clrm_pkg::*;
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/command_line_rule_matcher.sv
// ----------------------------------------------------------------------------
// command_line_rule_matcher
// A line's last item is held in the input register until the output is
// free; its verdict is then registered. Throughput: one character per
// cycle while no last item is held, window compare and flag update acting
// on the input register. Reset: arst_n clears the window, flags, counter
// and valid bits; all but the valid bits clear after each line's last item.
// ----------------------------------------------------------------------------
module command_line_rule_matcher #(
	parameter int MAX_CHARS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	clrm_char_if.sink   char_stream,
	clrm_res_if.source  verdict_stream
);
	import clrm_pkg::*;

	localparam int CNT_W = $clog2(MAX_CHARS);
	localparam logic [CNT_W-1:0] TAKEN_LIMIT = CNT_W'(MAX_CHARS - 1);

	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	logic              valid_s1;

	logic [CHAR_W-1:0] window_q [WIN_DEPTH];
	pat_flags_t        seen_q;
	logic [CNT_W-1:0]  taken_q;
	logic              stopped_q;

	logic              out_valid_q;
	verdict_t          verdict_q;

	logic              out_free;
	logic              s1_adv;
	logic [CHAR_W-1:0] low_char;
	logic [CHAR_W-1:0] hist [WIN_LEN];
	pat_flags_t        hit;
	pat_flags_t        seen_next;
	logic              stop_now;
	logic              take;

	assign out_free = !out_valid_q || verdict_stream.ready;
	assign s1_adv = valid_s1 && (!last_s1 || out_free);
	assign char_stream.ready = !valid_s1 || s1_adv;

	assign verdict_stream.valid = out_valid_q;
	assign verdict_stream.data.verdict = verdict_q;

	assign low_char = (char_s1 >= UPPER_FIRST && char_s1 <= UPPER_LAST) ?
		char_s1 + CASE_OFFSET : char_s1;

	always_comb begin
		hist[0] = low_char;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			hist[i+1] = window_q[i];
		end
	end

	// parallel window comparators, zero pattern bytes are don't care
	always_comb begin
		for (int p = 0; p < PAT_COUNT; p++) begin
			hit[p] = 1'b1;
			for (int i = 0; i < WIN_LEN; i++) begin
				if (PAT_TEXT[p][8*i +: 8] != 8'h00 &&
						hist[i] != {8'h00, PAT_TEXT[p][8*i +: 8]}) begin
					hit[p] = 1'b0;
				end
			end
		end
	end

	assign stop_now = (char_s1 == NUL_CHAR) || (taken_q >= TAKEN_LIMIT);
	assign take = !stopped_q && !stop_now;
	assign seen_next = take ? (seen_q | hit) : seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.valid && char_stream.ready) begin
			char_s1 <= char_stream.data.char_code;
			last_s1 <= char_stream.data.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				window_q[i] <= '0;
			end
			seen_q    <= '0;
			taken_q   <= '0;
			stopped_q <= 1'b0;
		end else if (s1_adv) begin
			if (last_s1) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					window_q[i] <= '0;
				end
				seen_q    <= '0;
				taken_q   <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (stop_now) begin
					stopped_q <= 1'b1;
				end else begin
					window_q[0] <= low_char;
					for (int i = 1; i < WIN_DEPTH; i++) begin
						window_q[i] <= window_q[i-1];
					end
					seen_q  <= seen_next;
					taken_q <= taken_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict_stream.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && last_s1) begin
			verdict_q <= decide(seen_next);
		end
	end

endmodule

// File: hw/rtl/clrm_checker.sv
// ----------------------------------------------------------------------------
// clrm_checker
// Port-level checks of the matcher: verdicts only for transferred last
// characters, bounded buffering, input ready when nothing is pending, stable stalled output and verdict codes in range.
// ----------------------------------------------------------------------------
module clrm_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              in_last,
	input logic              out_valid,
	input logic              out_ready,
	input clrm_pkg::verdict_t out_verdict
);
	import clrm_pkg::*;

	logic [2:0] pend_q;
	logic       in_xfer;
	logic       out_xfer;

	assign in_xfer  = in_valid && in_ready && in_last;
	assign out_xfer = out_valid && out_ready;

	// last characters transferred whose verdict is not yet taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {2'b00, in_xfer} - {2'b00, out_xfer};
		end
	end

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 3'd0)
		else $error("verdict without a pending last character");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 3'd2)
		else $error("more than two verdicts buffered");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 3'd0 |-> in_ready)
		else $error("input stalled with no verdict pending");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_verdict))
		else $error("stalled verdict changed");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_verdict <= VERDICT_LOLBIN)
		else $error("verdict code out of range");

endmodule

bind command_line_rule_matcher clrm_checker u_clrm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (char_stream.valid),
	.in_ready    (char_stream.ready),
	.in_last     (char_stream.data.last),
	.out_valid   (verdict_stream.valid),
	.out_ready   (verdict_stream.ready),
	.out_verdict (verdict_stream.data.verdict)
);

// File: test/clrm_checker.sv
// ----------------------------------------------------------------------------
// clrm_tb_checker
// Watches the character and verdict channels of the command line rule
// matcher. It keeps its own window, substring flags and length count,
// predicts the verdict of each line on its last character, and compares
// every verdict transfer with the oldest prediction.
// ----------------------------------------------------------------------------
package clrm_words_pkg;

	import clrm_pkg::*;

	// lowercase text of each watched substring, indexed by flag position
	function automatic string word_text(input int idx);
		string w;
		case (idx)
			P_SHADOW_TOOL: begin
				w = "vss";
				w = {w, "admin"};
			end
			P_DELETE:       w = "delete";
			P_SHADOW:       w = "shadow";
			P_SHADOWCOPY:   w = "shadowcopy";
			P_BACKUP_TOOL: begin
				w = "wb";
				w = {w, "admin"};
			end
			P_CATALOG:      w = "catalog";
			P_PS_FULL: begin
				w = "power";
				w = {w, "shell"};
			end
			P_PS_CORE:      w = "pwsh";
			P_WINSTYLE_LNG: w = "-windowstyle hidden";
			P_WINSTYLE_W:   w = "-w hidden";
			P_WINSTYLE_WIN: w = "-win hidden";
			P_ENC_SHORT:    w = "-enc ";
			P_ENC_LONG:     w = "-encodedcommand ";
			P_EXEC_LONG:    w = "-executionpolicy bypass";
			P_EXEC_EP:      w = "-ep bypass";
			P_EXEC_TIGHT:   w = "-epbypass";
			P_DL_STRING:    w = "downloadstring";
			P_DL_FILE:      w = "downloadfile";
			P_WEBREQ:       w = "invoke-webrequest";
			P_WEBCLIENT:    w = "net.webclient";
			P_BITS:         w = "start-bitstransfer";
			P_CERT_TOOL: begin
				w = "cert";
				w = {w, "util"};
			end
			P_URLCACHE:     w = "-urlcache";
			P_HTA_HOST: begin
				w = "msh";
				w = {w, "ta"};
			end
			P_HTTP:         w = "http";
			P_JS:           w = "javascript";
			P_VBS:          w = "vbscript";
			P_DLL_HOST: begin
				w = "run";
				w = {w, "dll32"};
			end
			P_JS_URI:       w = "javascript:";
			default:        w = "";
		endcase
		return w;
	endfunction

endpackage

module clrm_tb_checker #(
	parameter int MAX_CHARS = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	clrm_char_if       char_stream,
	clrm_res_if        verdict_stream,
	output int         mismatches,
	output int         waiting,
	output int         lines_done,
	output int         chars_done,
	output logic [6:0] verdict_mask
);

	import clrm_pkg::*;
	import clrm_words_pkg::*;

	logic [CHAR_W-1:0] past_chars [WIN_DEPTH];
	pat_flags_t        seen_flags;
	int                taken;
	bit                halted;
	verdict_t          verdict_q[$];
	int                bad_count;
	int                line_count;
	int                char_count;
	int                checked;
	verdict_t          want;
	verdict_t          got;

	task automatic clear_line();
		for (int i = 0; i < WIN_DEPTH; i++) begin
			past_chars[i] = '0;
		end
		seen_flags = '0;
		taken = 0;
		halted = 1'b0;
	endtask

	task automatic absorb_char(input logic [CHAR_W-1:0] raw);
		logic [CHAR_W-1:0] c;
		logic [CHAR_W-1:0] recent [WIN_LEN];
		string             w;
		int                n;
		bit                hit;
		c = raw;
		if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
			c = c + CASE_OFFSET;
		end
		recent[0] = c;
		for (int i = 0; i < WIN_DEPTH; i++) begin
			recent[i+1] = past_chars[i];
		end
		// newest character lines up with the last letter of each substring
		for (int p = 0; p < PAT_COUNT; p++) begin
			w = word_text(p);
			n = w.len();
			hit = 1'b1;
			for (int i = 0; i < n; i++) begin
				if (recent[i] != {8'h00, w[n-1-i]}) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				seen_flags[p] = 1'b1;
			end
		end
		for (int i = WIN_DEPTH - 1; i > 0; i--) begin
			past_chars[i] = past_chars[i-1];
		end
		past_chars[0] = c;
		taken++;
	endtask

	function automatic verdict_t rule_verdict(input pat_flags_t f);
		logic shell;
		logic wipe;
		logic lolbin;
		shell = f[P_PS_FULL] | f[P_PS_CORE];
		wipe = (f[P_SHADOW_TOOL] & f[P_DELETE] & f[P_SHADOW]) |
			(f[P_SHADOWCOPY] & f[P_DELETE]) |
			(f[P_BACKUP_TOOL] & f[P_DELETE] & f[P_CATALOG]);
		lolbin = (f[P_CERT_TOOL] & f[P_URLCACHE]) |
			(f[P_HTA_HOST] & (f[P_HTTP] | f[P_JS] | f[P_VBS])) |
			(f[P_DLL_HOST] & f[P_JS_URI]);
		if (wipe) begin
			return VERDICT_SHADOW_DELETE;
		end
		if (shell & (f[P_WINSTYLE_LNG] | f[P_WINSTYLE_W] | f[P_WINSTYLE_WIN])) begin
			return VERDICT_HIDDEN_SHELL;
		end
		if (shell & (f[P_ENC_SHORT] | f[P_ENC_LONG])) begin
			return VERDICT_ENCODED;
		end
		if (shell & (f[P_EXEC_LONG] | f[P_EXEC_EP] | f[P_EXEC_TIGHT])) begin
			return VERDICT_POLICY_BYPASS;
		end
		if (f[P_DL_STRING] | f[P_DL_FILE] | f[P_WEBREQ] | f[P_WEBCLIENT] | f[P_BITS]) begin
			return VERDICT_DOWNLOAD;
		end
		if (lolbin) begin
			return VERDICT_LOLBIN;
		end
		return VERDICT_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			verdict_q.delete();
			bad_count = 0;
			line_count = 0;
			char_count = 0;
			checked = 0;
			mismatches <= 0;
			waiting <= 0;
			lines_done <= 0;
			chars_done <= 0;
			verdict_mask <= '0;
		end else begin
			if (char_stream.valid && char_stream.ready) begin
				char_count++;
				if (!halted) begin
					if (char_stream.data.char_code == NUL_CHAR || taken >= MAX_CHARS - 1) begin
						halted = 1'b1;
					end else begin
						absorb_char(char_stream.data.char_code);
					end
				end
				if (char_stream.data.last) begin
					verdict_q.push_back(rule_verdict(seen_flags));
					clear_line();
					line_count++;
				end
			end
			if (verdict_stream.valid && verdict_stream.ready) begin
				got = verdict_stream.data.verdict;
				checked++;
				if (verdict_q.size() == 0) begin
					if (bad_count < 10) begin
						$display("verdict transfer %0d: none expected, got %0d", checked, got);
					end
					bad_count++;
				end else begin
					want = verdict_q.pop_front();
					if (got != want) begin
						if (bad_count < 10) begin
							$display("verdict transfer %0d: expected %0d, got %0d",
								checked, want, got);
						end
						bad_count++;
					end
				end
				verdict_mask[got] <= 1'b1;
			end
			mismatches <= bad_count;
			waiting <= verdict_q.size();
			lines_done <= line_count;
			chars_done <= char_count;
		end
	end

endmodule

// File: test/command_line_rule_matcher_tb.sv
// ----------------------------------------------------------------------------
// command_line_rule_matcher_tb
// Streams command lines into the rule matcher: directed lines for each
// verdict, rule priority, case folding, NUL stop and the length limit, then
// random lines built mostly from substrings that satisfy or nearly satisfy
// a rule, under four mixes of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module command_line_rule_matcher_tb;

	import clrm_pkg::*;
	import clrm_words_pkg::*;

	localparam int MAX_CHARS    = 1024;
	localparam int RANDOM_ITEMS = 900;
	localparam int RANDOM_LINES = 50;
	localparam int CYCLE_LIMIT  = 200000;

	localparam logic [CHAR_W-1:0] LOWER_FIRST = 16'h0061;
	localparam logic [CHAR_W-1:0] LOWER_LAST  = 16'h007A;

	logic clk = 1'b0;
	logic arst_n;

	clrm_char_if char_if();
	clrm_res_if  res_if();

	int mismatches;
	int waiting;
	int lines_done;
	int chars_done;
	logic [6:0] verdict_mask;

	int idle_pct;
	int stall_pct;
	int cycles = 0;
	int random_items;
	int random_lines;
	logic [CHAR_W-1:0] line_buf[$];

	command_line_rule_matcher #(
		.MAX_CHARS(MAX_CHARS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.char_stream(char_if),
		.verdict_stream(res_if)
	);

	clrm_tb_checker #(
		.MAX_CHARS(MAX_CHARS)
	) rule_check (
		.clk(clk),
		.arst_n(arst_n),
		.char_stream(char_if),
		.verdict_stream(res_if),
		.mismatches(mismatches),
		.waiting(waiting),
		.lines_done(lines_done),
		.chars_done(chars_done),
		.verdict_mask(verdict_mask)
	);

	always #6 clk = ~clk;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			res_if.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d verdicts outstanding", cycles, waiting);
			$display("command_line_rule_matcher_tb: done, errors");
			$finish;
		end
	end

	task automatic send_char(input logic [CHAR_W-1:0] c, input logic l);
		if ($urandom_range(99) < idle_pct) begin
			char_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		char_if.valid <= 1'b1;
		char_if.data <= {c, l};
		@(posedge clk);
		while (!char_if.ready) @(posedge clk);
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++) begin
			send_char(line_buf[i], i == line_buf.size() - 1);
		end
		line_buf.delete();
	endtask

	task automatic put(input string s);
		for (int i = 0; i < s.len(); i++) begin
			line_buf.push_back({8'h00, s[i]});
		end
	endtask

	task automatic fill(input int n);
		for (int i = 0; i < n; i++) begin
			line_buf.push_back(16'h0078);
		end
	endtask

	// mode 0 lowercase, 1 uppercase, 2 random case per letter
	task automatic add_word(input int idx, input int mode);
		string w;
		logic [CHAR_W-1:0] c;
		w = word_text(idx);
		for (int i = 0; i < w.len(); i++) begin
			c = {8'h00, w[i]};
			if (c >= LOWER_FIRST && c <= LOWER_LAST &&
					(mode == 1 || (mode == 2 && $urandom_range(1)))) begin
				c = c - CASE_OFFSET;
			end
			line_buf.push_back(c);
		end
	endtask

	task automatic add_noise(input int n, input bit wide);
		for (int i = 0; i < n; i++) begin
			if (wide && $urandom_range(1)) begin
				line_buf.push_back(CHAR_W'($urandom_range(16'hFFFF, 1)));
			end else begin
				line_buf.push_back(CHAR_W'($urandom_range(16'h007E, 16'h0020)));
			end
		end
	endtask

	// substrings that satisfy one clause of a rule; broken drops one of them
	task automatic add_rule(input int v, input bit broken);
		int words[$];
		int shell;
		int pick;
		shell = $urandom_range(1) ? P_PS_FULL : P_PS_CORE;
		pick = $urandom_range(2);
		case (v)
			VERDICT_SHADOW_DELETE: begin
				if (pick == 0) begin
					words = '{P_SHADOW_TOOL, P_DELETE, P_SHADOW};
				end else if (pick == 1) begin
					words = '{P_SHADOWCOPY, P_DELETE};
				end else begin
					words = '{P_BACKUP_TOOL, P_DELETE, P_CATALOG};
				end
			end
			VERDICT_HIDDEN_SHELL: begin
				words = '{shell, P_WINSTYLE_LNG + pick};
			end
			VERDICT_ENCODED: begin
				words = '{shell, P_ENC_SHORT + $urandom_range(1)};
			end
			VERDICT_POLICY_BYPASS: begin
				words = '{shell, P_EXEC_LONG + pick};
			end
			VERDICT_DOWNLOAD: begin
				words = '{P_DL_STRING + $urandom_range(4)};
			end
			default: begin
				if (pick == 0) begin
					words = '{P_CERT_TOOL, P_URLCACHE};
				end else if (pick == 1) begin
					words = '{P_HTA_HOST, P_HTTP + $urandom_range(2)};
				end else begin
					words = '{P_DLL_HOST, P_JS_URI};
				end
			end
		endcase
		if (broken) begin
			words.delete($urandom_range(words.size() - 1));
		end
		for (int i = 0; i < words.size(); i++) begin
			if (i > 0) begin
				line_buf.push_back(16'h0020);
			end
			add_word(words[i], 2);
		end
	endtask

	task automatic make_random_line();
		int kind;
		int parts;
		kind = $urandom_range(99);
		parts = $urandom_range(3, 1);
		for (int k = 0; k < parts; k++) begin
			if ($urandom_range(19) == 0) begin
				line_buf.push_back(NUL_CHAR);
			end
			if ($urandom_range(1)) begin
				add_noise($urandom_range(4, 1), kind >= 85);
			end
			if (kind < 70) begin
				add_rule($urandom_range(VERDICT_LOLBIN, VERDICT_SHADOW_DELETE),
					$urandom_range(9) == 0);
			end else if (kind < 85) begin
				add_word($urandom_range(PAT_COUNT - 1), 2);
			end else begin
				add_noise($urandom_range(12, 1), 1'b1);
			end
		end
		if ($urandom_range(2) == 0) begin
			add_noise($urandom_range(3, 1), 1'b0);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		char_if.valid <= 1'b0;
		char_if.data <= '0;
		idle_pct = 0;
		stall_pct = 0;
		random_items = 0;
		random_lines = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty line and all-ones character
		line_buf.push_back(NUL_CHAR);
		send_line();
		line_buf.push_back(16'hFFFF);
		send_line();

		// lines for each verdict, most ending on the last character of a substring
		add_word(P_SHADOW_TOOL, 1); put(" ");
		add_word(P_DELETE, 1); put(" ");
		add_word(P_SHADOW, 1); put("S /ALL");
		send_line();
		add_word(P_BACKUP_TOOL, 2); put(" ");
		add_word(P_DELETE, 0); put(" ");
		add_word(P_CATALOG, 2);
		send_line();
		add_word(P_PS_FULL, 2); put(" ");
		add_word(P_WINSTYLE_W, 0);
		send_line();
		add_word(P_PS_CORE, 0); put(" ");
		add_word(P_ENC_SHORT, 1);
		send_line();
		add_word(P_PS_FULL, 0); put(" ");
		add_word(P_EXEC_LONG, 2); put(" ");
		add_word(P_EXEC_EP, 0); put(" ");
		add_word(P_EXEC_TIGHT, 1);
		send_line();
		add_word(P_DL_STRING, 2); put(" ");
		add_word(P_WEBREQ, 0); put(" ");
		add_word(P_BITS, 1);
		send_line();
		add_word(P_WEBCLIENT, 0); put(".");
		add_word(P_DL_FILE, 0);
		send_line();
		add_word(P_CERT_TOOL, 2); put(" ");
		add_word(P_URLCACHE, 2);
		send_line();
		add_word(P_HTA_HOST, 0); put(" ");
		add_word(P_HTTP, 2); put(" ");
		add_word(P_JS, 0); put(" ");
		add_word(P_VBS, 1);
		send_line();
		add_word(P_DLL_HOST, 1); put(" ");
		add_word(P_JS_URI, 0);
		send_line();

		// rule priority
		add_word(P_SHADOWCOPY, 0); put(" ");
		add_word(P_DELETE, 0); put(" ");
		add_word(P_PS_CORE, 0); put(" ");
		add_word(P_WINSTYLE_WIN, 0);
		send_line();
		add_word(P_PS_CORE, 0); put(" ");
		add_word(P_ENC_LONG, 0);
		add_word(P_WINSTYLE_LNG, 0);
		send_line();

		// partial rules, and flags not carried into the next line
		add_word(P_ENC_LONG, 0); put(" ");
		add_word(P_WINSTYLE_W, 0);
		send_line();
		add_word(P_PS_CORE, 0);
		send_line();

		// NUL ends inspection, later text is ignored
		add_word(P_PS_CORE, 0);
		line_buf.push_back(NUL_CHAR);
		add_word(P_WINSTYLE_W, 0);
		send_line();

		// case folding edges and characters with high bits set
		line_buf.push_back(16'h0040);
		line_buf.push_back(16'h005B);
		line_buf.push_back(16'h0060);
		line_buf.push_back(16'h007B);
		line_buf.push_back(16'h4100);
		line_buf.push_back(16'h8041);
		put("AZ ");
		put("pws");
		line_buf.push_back(16'h0168);
		put(" ");
		add_word(P_WINSTYLE_W, 0);
		send_line();

		// length limit: substring ending on the last inspected character, then one later
		add_word(P_WINSTYLE_W, 0);
		fill(MAX_CHARS - 1 - word_text(P_WINSTYLE_W).len() - word_text(P_PS_CORE).len());
		add_word(P_PS_CORE, 0);
		send_line();
		add_word(P_WINSTYLE_W, 0);
		fill(MAX_CHARS - word_text(P_WINSTYLE_W).len() - word_text(P_PS_CORE).len());
		add_word(P_PS_CORE, 0);
		send_line();

		// random lines in four handshake mixes
		while (random_items < RANDOM_ITEMS || random_lines < RANDOM_LINES) begin
			case (random_items * 4 / RANDOM_ITEMS)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 85;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 85;
				end
				default: begin
					idle_pct = 14;
					stall_pct = 14;
				end
			endcase
			make_random_line();
			random_items += line_buf.size();
			random_lines++;
			send_line();
		end
		char_if.valid <= 1'b0;

		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d lines, %0d characters (%0d random lines) over four handshake mixes",
			lines_done, chars_done, random_lines);
		$display("verdict kinds observed, one bit per kind: %b", verdict_mask);
		if (mismatches == 0 && waiting == 0) begin
			$display("command_line_rule_matcher_tb: done, clean");
		end else begin
			$display("command_line_rule_matcher_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/clrm_pkg.sv
hw/rtl/clrm_ifs.sv
hw/rtl/command_line_rule_matcher.sv
hw/rtl/clrm_checker.sv
test/clrm_checker.sv
test/command_line_rule_matcher_tb.sv
